/* sv/srx_pkg.sv */
// Package for the scrypt ROMix core: constants, state enum and Salsa20 helpers.
// No dependencies; used by scrypt_romix_salsa20_8.
package srx_pkg;

	localparam int unsigned BLOCK_R_DEF = 1;
	localparam int unsigned MAX_N_DEF   = 1024;
	localparam logic [3:0]  COST_RESET  = 4'd10;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_MIX_INIT,
		ST_PAD_WR,
		ST_XOR_RD,
		ST_XOR_WAIT,
		ST_XOR_APPLY,
		ST_SALSA_LOAD,
		ST_SALSA_RUN,
		ST_SALSA_FIN,
		ST_EMIT
	} srx_state_t;

	function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
		rotl32 = (v << n) | (v >> (6'd32 - {1'b0, n}));
	endfunction

	// Quarter-round index tables for the eight quarter rounds of one double round.
	function automatic logic [15:0] qr_idx(input logic [2:0] q);
		logic [15:0] r;
		case (q)
			3'd0: r = {4'd0, 4'd4, 4'd8, 4'd12};
			3'd1: r = {4'd5, 4'd9, 4'd13, 4'd1};
			3'd2: r = {4'd10, 4'd14, 4'd2, 4'd6};
			3'd3: r = {4'd15, 4'd3, 4'd7, 4'd11};
			3'd4: r = {4'd0, 4'd1, 4'd2, 4'd3};
			3'd5: r = {4'd5, 4'd6, 4'd7, 4'd4};
			3'd6: r = {4'd10, 4'd11, 4'd8, 4'd9};
			3'd7: r = {4'd15, 4'd12, 4'd13, 4'd14};
			default: r = '0;
		endcase
		qr_idx = r;
	endfunction

endpackage

/* sv/scrypt_romix_salsa20_8.sv */
// Scrypt ROMix core with Salsa20/8 BlockMix, one add-rotate-xor step per cycle.
// Depends on srx_pkg. W = 32*R words: each Salsa20/8 core runs 128 steps, a pad entry
// is filled one word at a time, and each word is folded back in by a read, wait and
// apply step; output goes out one word per cycle while out_ready is high.
// One block at a time: in_ready stays low from the completing word until the last
// word is taken. Reset clears control state and sets the stored cost to 10.
module scrypt_romix_salsa20_8 #(
	parameter int unsigned BLOCK_R = srx_pkg::BLOCK_R_DEF,
	parameter int unsigned MAX_N   = srx_pkg::MAX_N_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cost_log2,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] in_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] out_word,
	output logic        out_last
);
	import srx_pkg::*;

	localparam int unsigned W     = 32 * BLOCK_R;
	localparam int unsigned WB    = $clog2(W);
	localparam int unsigned NB    = $clog2(MAX_N);
	localparam int unsigned NLOG  = $clog2(MAX_N + 1) - 1;
	localparam int unsigned SUBS  = 2 * BLOCK_R;
	localparam int unsigned SB    = (SUBS > 1) ? $clog2(SUBS) : 1;
	localparam int unsigned PAD   = W * MAX_N;
	localparam int unsigned PB    = $clog2(PAD);
	localparam int unsigned LAST  = 16 * (SUBS - 1);

	srx_state_t state_q, state_d;

	logic [3:0]    cost_q;
	logic [31:0]   work_q [W];
	logic [31:0]   mix_q  [W];
	logic [31:0]   x_q    [16];
	logic [31:0]   sst_q  [16];
	logic [31:0]   pad_mem [PAD];
	logic [31:0]   pad_rd_q;
	logic [WB:0]   wcnt_q;
	logic [NB:0]   ncnt_q;
	logic          phase_q;
	logic [SB-1:0] sub_q;
	logic [6:0]    qcnt_q;
	logic [NB-1:0] j_q;
	logic [NB:0]   n_val;
	logic [4:0]    c_eff;
	logic [WB-1:0] widx;
	logic [15:0]   qi;
	logic [3:0]    ia, ib, ic, id;
	logic [3:0]    dsel, s1sel, s2sel;
	logic [4:0]    rsel;
	logic [31:0]   step_val;

	assign cfg_ready = (state_q == ST_LOAD);
	assign widx      = wcnt_q[WB-1:0];

	always_comb begin
		c_eff = (cost_q == 4'd0) ? 5'd1 : {1'b0, cost_q};
		if (c_eff > 5'(NLOG))
			c_eff = 5'(NLOG);
		n_val = (NB+1)'(1) << c_eff;
	end

	always_comb begin
		qi = qr_idx(qcnt_q[4:2]);
		ia = qi[15:12];
		ib = qi[11:8];
		ic = qi[7:4];
		id = qi[3:0];
		case (qcnt_q[1:0])
			2'd0: begin
				dsel  = ib;
				s1sel = ia;
				s2sel = id;
				rsel  = 5'd7;
			end
			2'd1: begin
				dsel  = ic;
				s1sel = ib;
				s2sel = ia;
				rsel  = 5'd9;
			end
			2'd2: begin
				dsel  = id;
				s1sel = ic;
				s2sel = ib;
				rsel  = 5'd13;
			end
			default: begin
				dsel  = ia;
				s1sel = id;
				s2sel = ic;
				rsel  = 5'd18;
			end
		endcase
		step_val = x_q[dsel] ^ rotl32(x_q[s1sel] + x_q[s2sel], rsel);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:
				if (in_valid && wcnt_q == (WB+1)'(W - 1))
					state_d = ST_PAD_WR;
			ST_PAD_WR:
				if (wcnt_q == (WB+1)'(W - 1))
					state_d = ST_MIX_INIT;
			ST_XOR_RD:    state_d = ST_XOR_WAIT;
			ST_XOR_WAIT:  state_d = ST_XOR_APPLY;
			ST_XOR_APPLY:
				state_d = (wcnt_q == (WB+1)'(W - 1)) ? ST_MIX_INIT : ST_XOR_RD;
			ST_MIX_INIT:  state_d = ST_SALSA_LOAD;
			ST_SALSA_LOAD: state_d = ST_SALSA_RUN;
			ST_SALSA_RUN:
				if (qcnt_q == 7'd127)
					state_d = ST_SALSA_FIN;
			ST_SALSA_FIN:
				if (sub_q == SB'(SUBS - 1)) begin
					if (ncnt_q == n_val - 1'b1)
						state_d = phase_q ? ST_EMIT : ST_XOR_RD;
					else
						state_d = phase_q ? ST_XOR_RD : ST_PAD_WR;
				end else
					state_d = ST_SALSA_LOAD;
			ST_EMIT:
				if (out_ready && wcnt_q == (WB+1)'(W - 1))
					state_d = ST_LOAD;
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_LOAD);
		out_valid = (state_q == ST_EMIT);
		out_word  = work_q[widx];
		out_last  = (wcnt_q == (WB+1)'(W - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cost_q  <= COST_RESET;
			wcnt_q  <= '0;
			ncnt_q  <= '0;
			phase_q <= 1'b0;
			sub_q   <= '0;
			qcnt_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready)
				cost_q <= cost_log2;
			case (state_q)
				ST_LOAD:
					if (in_valid) begin
						wcnt_q  <= (wcnt_q == (WB+1)'(W - 1)) ? '0 : wcnt_q + 1'b1;
						ncnt_q  <= '0;
						phase_q <= 1'b0;
					end
				ST_PAD_WR:
					wcnt_q <= (wcnt_q == (WB+1)'(W - 1)) ? '0 : wcnt_q + 1'b1;
				ST_XOR_APPLY:
					wcnt_q <= (wcnt_q == (WB+1)'(W - 1)) ? '0 : wcnt_q + 1'b1;
				ST_MIX_INIT: sub_q <= '0;
				ST_SALSA_LOAD: qcnt_q <= '0;
				ST_SALSA_RUN: qcnt_q <= qcnt_q + 1'b1;
				ST_SALSA_FIN:
					if (sub_q == SB'(SUBS - 1)) begin
						if (ncnt_q == n_val - 1'b1) begin
							ncnt_q  <= '0;
							phase_q <= 1'b1;
						end else
							ncnt_q <= ncnt_q + 1'b1;
					end else
						sub_q <= sub_q + 1'b1;
				ST_EMIT:
					if (out_ready)
						wcnt_q <= (wcnt_q == (WB+1)'(W - 1)) ? '0 : wcnt_q + 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD:
				if (in_valid)
					work_q[widx] <= in_word;
			ST_PAD_WR:
				pad_mem[PB'(ncnt_q[NB-1:0]) * PB'(W) + PB'(widx)] <= work_q[widx];
			ST_XOR_RD: begin
				if (wcnt_q == '0)
					j_q <= work_q[LAST][NB-1:0] & NB'(n_val - 1'b1);
				pad_rd_q <= pad_mem[PB'((wcnt_q == '0)
					? (work_q[LAST][NB-1:0] & NB'(n_val - 1'b1)) : j_q) * PB'(W)
					+ PB'(widx)];
			end
			ST_XOR_APPLY:
				work_q[widx] <= work_q[widx] ^ pad_rd_q;
			ST_MIX_INIT:
				for (int k = 0; k < 16; k++)
					sst_q[k] <= work_q[LAST + k];
			ST_SALSA_LOAD:
				for (int k = 0; k < 16; k++) begin
					sst_q[k] <= sst_q[k] ^ work_q[WB'(32'(sub_q) * 16 + k)];
					x_q[k]   <= sst_q[k] ^ work_q[WB'(32'(sub_q) * 16 + k)];
				end
			ST_SALSA_RUN:
				x_q[dsel] <= step_val;
			ST_SALSA_FIN: begin
				for (int k = 0; k < 16; k++) begin
					sst_q[k] <= sst_q[k] + x_q[k];
					mix_q[WB'(32'(sub_q) * 16 + k)] <= sst_q[k] + x_q[k];
				end
				if (sub_q == SB'(SUBS - 1))
					for (int i = 0; i < BLOCK_R; i++)
						for (int k = 0; k < 16; k++) begin
							work_q[i * 16 + k] <= (2 * i == SUBS - 1)
								? sst_q[k] + x_q[k] : mix_q[2 * i * 16 + k];
							work_q[(i + BLOCK_R) * 16 + k] <= (2 * i + 1 == SUBS - 1)
								? sst_q[k] + x_q[k] : mix_q[(2 * i + 1) * 16 + k];
						end
			end
			default: ;
		endcase
	end

endmodule

/* verif/srx_checker.sv */
`timescale 1ns / 1ps
// Checker for scrypt_romix_salsa20_8: watches the config, input and output channels,
// predicts each mixed block and compares it word by word. Depends on srx_pkg.
module srx_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [3:0]  cost_log2,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] in_word,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] out_word,
	input  logic        out_last,
	output int          fails,
	output int          pending,
	output int          words_checked
);
	import srx_pkg::*;

	localparam int unsigned BLK_W = 32 * BLOCK_R_DEF;

	typedef logic [15:0][31:0] w16_t;
	typedef logic [BLK_W-1:0][31:0] blk_t;

	blk_t        work;
	blk_t        pad_mem [0:MAX_N_DEF-1];
	logic [3:0]  cost_q;
	int unsigned fill;
	logic [31:0] exp_word [$];
	logic        exp_last [$];

	function automatic logic [31:0] rot(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic w16_t quarter_rd(input w16_t x, input int a, input int b,
			input int c, input int d);
		x[b] ^= rot(x[a] + x[d], 7);
		x[c] ^= rot(x[b] + x[a], 9);
		x[d] ^= rot(x[c] + x[b], 13);
		x[a] ^= rot(x[d] + x[c], 18);
		return x;
	endfunction

	function automatic w16_t salsa8(input w16_t s);
		w16_t x;
		x = s;
		for (int i = 0; i < 4; i++) begin
			x = quarter_rd(x, 0, 4, 8, 12);
			x = quarter_rd(x, 5, 9, 13, 1);
			x = quarter_rd(x, 10, 14, 2, 6);
			x = quarter_rd(x, 15, 3, 7, 11);
			x = quarter_rd(x, 0, 1, 2, 3);
			x = quarter_rd(x, 5, 6, 7, 4);
			x = quarter_rd(x, 10, 11, 8, 9);
			x = quarter_rd(x, 15, 12, 13, 14);
		end
		for (int i = 0; i < 16; i++)
			x[i] = x[i] + s[i];
		return x;
	endfunction

	function automatic blk_t block_mix(input blk_t b);
		w16_t x;
		blk_t y;
		blk_t r;
		for (int k = 0; k < 16; k++)
			x[k] = b[(2 * BLOCK_R_DEF - 1) * 16 + k];
		for (int i = 0; i < 2 * BLOCK_R_DEF; i++) begin
			for (int k = 0; k < 16; k++)
				x[k] ^= b[i * 16 + k];
			x = salsa8(x);
			for (int k = 0; k < 16; k++)
				y[i * 16 + k] = x[k];
		end
		for (int i = 0; i < BLOCK_R_DEF; i++)
			for (int k = 0; k < 16; k++) begin
				r[i * 16 + k] = y[2 * i * 16 + k];
				r[(i + BLOCK_R_DEF) * 16 + k] = y[(2 * i + 1) * 16 + k];
			end
		return r;
	endfunction

	function automatic int unsigned passes(input logic [3:0] c);
		int unsigned n;
		n = 1 << ((c < 1) ? 1 : c);
		while (n > MAX_N_DEF)
			n >>= 1;
		return n;
	endfunction

	task automatic run_romix();
		int unsigned n;
		int unsigned j;
		n = passes(cost_q);
		for (int unsigned i = 0; i < n; i++) begin
			pad_mem[i] = work;
			work = block_mix(work);
		end
		for (int unsigned i = 0; i < n; i++) begin
			j = work[16 * (2 * BLOCK_R_DEF - 1)] & (n - 1);
			work = block_mix(work ^ pad_mem[j]);
		end
		for (int k = 0; k < BLK_W; k++) begin
			exp_word.push_back(work[k]);
			exp_last.push_back(k == BLK_W - 1);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cost_q = COST_RESET;
			fill = 0;
			exp_word.delete();
			exp_last.delete();
			fails = 0;
			pending = 0;
			words_checked = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				cost_q = cost_log2;
			if (out_valid && out_ready) begin
				if (exp_word.size() == 0) begin
					$error("unexpected output word %h", out_word);
					fails++;
				end else begin
					if (out_word !== exp_word[0]) begin
						$error("out_word expected %h actual %h", exp_word[0], out_word);
						fails++;
					end
					if (out_last !== exp_last[0]) begin
						$error("out_last expected %b actual %b", exp_last[0], out_last);
						fails++;
					end
					void'(exp_word.pop_front());
					void'(exp_last.pop_front());
					words_checked++;
				end
			end
			if (in_valid && in_ready) begin
				work[fill] = in_word;
				fill++;
				if (fill == BLK_W) begin
					fill = 0;
					run_romix();
				end
			end
			pending = exp_word.size();
		end
	end

endmodule

/* verif/tb_scrypt_romix_salsa20_8.sv */
`timescale 1ns / 1ps
// Testbench top for scrypt_romix_salsa20_8: drives config, input blocks and output stalls,
// and gives the verdict from srx_checker. Depends on srx_pkg and srx_checker.
module tb_scrypt_romix_salsa20_8;
	import srx_pkg::*;

	localparam int WATCH_LIMIT = 4000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cost_log2 = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] in_word = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] out_word;
	logic        out_last;

	int fails;
	int pending;
	int words_checked;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int blocks_sent = 0;
	int idle_cnt = 0;

	scrypt_romix_salsa20_8 u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cost_log2(cost_log2),
		.in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_word(out_word), .out_last(out_last)
	);

	srx_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cost_log2(cost_log2),
		.in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_word(out_word), .out_last(out_last),
		.fails(fails), .pending(pending), .words_checked(words_checked)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WATCH_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_word(input logic [31:0] w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_cost(input logic [3:0] c);
		drain();
		cfg_valid <= 1'b1;
		cost_log2 <= c;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random_block();
		for (int i = 0; i < 32; i++)
			send_word($urandom);
		blocks_sent++;
	endtask

	initial begin
		logic [31:0] pattern [8];
		pattern = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h1,
			32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF, 32'hFFFF_FFFE};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// lowest cost, extreme word values
		set_cost(4'd0);
		for (int i = 0; i < 32; i++)
			send_word(i < 8 ? pattern[i] : 32'h0101_0101 * i);
		blocks_sent++;

		// saturated cost, all register bits high
		set_cost(4'd15);
		send_random_block();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 63 : 0;
			recv_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 15 : 0;
			set_cost(4'($urandom_range(4, 1)));
			send_random_block();
			if (ph == 2)
				send_random_block();
		end

		drain();
		repeat (100) @(posedge clk);
		$display("Checked %0d words over %0d input blocks; costs 0, 15 and 1..4,",
			words_checked, blocks_sent);
		$display("with sender and receiver stalls in three idling profiles.");
		if (fails == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
